// File: rtl/spdd_pkg.sv
// ----------------------------------------------------------------------------
// spdd_pkg
// Shared types, constants and field decode tables for the packet deframer.
// ----------------------------------------------------------------------------
package spdd_pkg;

    // packet buffer geometry
    localparam int PACKET_DEPTH = 32;
    localparam int POS_W        = $clog2(PACKET_DEPTH);
    localparam int NUM_BANKS    = 2;
    localparam int BANK_W       = $clog2(NUM_BANKS);
    localparam int ADDR_W       = POS_W + BANK_W;
    localparam int LEN_W        = 7;
    localparam int MIN_LENGTH   = 22;
    localparam int QUEUE_DEPTH  = NUM_BANKS;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int BYTE_W  = 8;
    localparam int CFGL_W  = 6;
    localparam int FIDX_W  = 4;
    localparam int VALUE_W = 25;

    // last field index of each packet kind
    localparam logic [FIDX_W-1:0] LAST_VEL = 4'd13;
    localparam logic [FIDX_W-1:0] LAST_SYS = 4'd11;

    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [FIDX_W-1:0]  t_fidx;
    typedef logic signed [VALUE_W-1:0] t_value;

    // packet kinds
    typedef enum logic {
        KIND_VEL = 1'b0,
        KIND_SYS = 1'b1
    } t_kind;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SYNC    = 2'd0,
        REG_VEL_ID  = 2'd1,
        REG_VEL_LEN = 2'd2,
        REG_SYS_LEN = 2'd3
    } t_reg_idx;

    // field decode operations
    typedef enum logic [2:0] {
        OP_BYTE,
        OP_S16,
        OP_U16,
        OP_PRESS,
        OP_BCD
    } t_op;

    // back end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RD0,
        BK_RD1,
        BK_RD2,
        BK_CAP,
        BK_OUT
    } t_bk_state;

    // one finished packet waiting for decode
    typedef struct packed {
        logic [BANK_W-1:0] bank;
        t_kind             kind;
    } t_job;

    // queue push from the front end
    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    // queue status towards both ends
    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    // buffer write port
    typedef struct packed {
        logic  we;
        t_addr addr;
        t_byte data;
    } t_wr;

    // one field: operation and the three byte positions it reads
    typedef struct packed {
        t_op  op;
        t_pos a0;
        t_pos a1;
        t_pos a2;
    } t_desc;

    function automatic t_desc mk_desc(t_op op, int p0, int p1, int p2);
        t_desc d;
        d.op = op;
        d.a0 = POS_W'(p0);
        d.a1 = POS_W'(p1);
        d.a2 = POS_W'(p2);
        return d;
    endfunction

    // field table: a0 is the low byte, a1 the next, a2 the pressure msb
    function automatic t_desc field_desc(t_kind kind, t_fidx idx);
        t_desc d;
        d = mk_desc(OP_BYTE, 3, 3, 3);
        if (kind == KIND_VEL) begin
            case (idx)
                4'd0:  d = mk_desc(OP_BYTE, 3, 3, 3);
                4'd1:  d = mk_desc(OP_PRESS, 6, 7, 4);
                4'd2:  d = mk_desc(OP_S16, 10, 11, 11);
                4'd3:  d = mk_desc(OP_S16, 12, 13, 13);
                4'd4:  d = mk_desc(OP_S16, 14, 15, 15);
                4'd5:  d = mk_desc(OP_BYTE, 16, 16, 16);
                4'd6:  d = mk_desc(OP_BYTE, 17, 17, 17);
                4'd7:  d = mk_desc(OP_BYTE, 18, 18, 18);
                4'd8:  d = mk_desc(OP_BYTE, 19, 19, 19);
                4'd9:  d = mk_desc(OP_BYTE, 20, 20, 20);
                4'd10: d = mk_desc(OP_BYTE, 21, 21, 21);
                4'd11: d = mk_desc(OP_BYTE, 2, 2, 2);
                4'd12: d = mk_desc(OP_U16, 2, 5, 5);
                4'd13: d = mk_desc(OP_S16, 8, 9, 9);
                default: d = mk_desc(OP_BYTE, 3, 3, 3);
            endcase
        end else begin
            case (idx)
                4'd0:  d = mk_desc(OP_BCD, 4, 4, 4);
                4'd1:  d = mk_desc(OP_BCD, 5, 5, 5);
                4'd2:  d = mk_desc(OP_BCD, 6, 6, 6);
                4'd3:  d = mk_desc(OP_BCD, 7, 7, 7);
                4'd4:  d = mk_desc(OP_BCD, 8, 8, 8);
                4'd5:  d = mk_desc(OP_BCD, 9, 9, 9);
                4'd6:  d = mk_desc(OP_S16, 10, 11, 11);
                4'd7:  d = mk_desc(OP_S16, 12, 13, 13);
                4'd8:  d = mk_desc(OP_S16, 14, 15, 15);
                4'd9:  d = mk_desc(OP_S16, 16, 17, 17);
                4'd10: d = mk_desc(OP_S16, 18, 19, 19);
                4'd11: d = mk_desc(OP_S16, 20, 21, 21);
                default: d = mk_desc(OP_BCD, 4, 4, 4);
            endcase
        end
        return d;
    endfunction

    // turn the gathered bytes into a field value
    function automatic t_value decode_value(t_op op, t_byte b0, t_byte b1, t_byte b2);
        t_value v;
        logic [BYTE_W-1:0] bcd;
        bcd = ({4'd0, b0[7:4]} << 3) + ({4'd0, b0[7:4]} << 1) + {4'd0, b0[3:0]};
        case (op)
            OP_BYTE:  v = {{(VALUE_W-8){1'b0}}, b0};
            OP_S16:   v = {{(VALUE_W-16){b1[7]}}, b1, b0};
            OP_U16:   v = {{(VALUE_W-16){1'b0}}, b1, b0};
            OP_PRESS: v = {{(VALUE_W-24){1'b0}}, b2, b1, b0};
            OP_BCD:   v = {{(VALUE_W-8){1'b0}}, bcd};
            default:  v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/spdd_ram.sv
// ----------------------------------------------------------------------------
// spdd_ram
// Simple dual port buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spdd_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/spdd_queue.sv
// ----------------------------------------------------------------------------
// spdd_queue
// Short job queue between the deframing front end and the decode back end.
// ----------------------------------------------------------------------------
module spdd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spdd_pkg::t_push i_push,
    input  logic           i_pop,
    output spdd_pkg::t_job  o_head,
    output spdd_pkg::t_qstat o_stat
);
    import spdd_pkg::*;

    t_job                     r_slot [QUEUE_DEPTH];
    logic [BANK_W-1:0]        r_wptr;
    logic [BANK_W-1:0]        r_rptr;
    logic [QCNT_W-1:0]        r_count;
    logic [BANK_W-1:0]        n_wptr;
    logic [BANK_W-1:0]        n_rptr;
    logic [QCNT_W-1:0]        n_count;

    // pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push.valid) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_push.valid && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slot[r_wptr] <= i_push.job;
        end
    end

    assign o_head       = r_slot[r_rptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full && !i_pop |-> !i_push.valid)
        else $error("job queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop)
        else $error("job queue pop while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("job queue count out of range");
`endif

endmodule

// File: rtl/spdd_front.sv
// ----------------------------------------------------------------------------
// spdd_front
// Front end: configuration registers, sync hunt, length choice and byte
// storage into the current buffer bank; hands finished packets to the queue.
// ----------------------------------------------------------------------------
module spdd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // byte stream
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  spdd_pkg::t_byte  i_s_tdata,
    // configuration writes
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  spdd_pkg::t_reg_idx i_cfg_index,
    input  spdd_pkg::t_byte  i_cfg_data,
    // buffer and queue
    output spdd_pkg::t_wr    o_wr,
    input  spdd_pkg::t_qstat i_qstat,
    output spdd_pkg::t_push  o_push
);
    import spdd_pkg::*;

    localparam t_pos POS_ONE = POS_W'(1);

    t_byte               r_sync;
    t_byte               r_vel_id;
    logic [CFGL_W-1:0]   r_vel_len;
    logic [CFGL_W-1:0]   r_sys_len;
    logic                r_receiving;
    t_pos                r_pos;
    t_len                r_len;
    t_byte               r_type;
    logic [BANK_W-1:0]   r_bank;

    logic                n_receiving;
    t_pos                n_pos;
    t_len                n_len;
    t_byte               n_type;
    logic [BANK_W-1:0]   n_bank;

    logic                accept;
    logic                is_sync;
    logic                done;
    t_len                len_pick;
    t_len                len_clamp;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync    <= 8'd165;
            r_vel_id  <= 8'd16;
            r_vel_len <= 6'd24;
            r_sys_len <= 6'd28;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SYNC:    r_sync    <= i_cfg_data;
                REG_VEL_ID:  r_vel_id  <= i_cfg_data;
                REG_VEL_LEN: r_vel_len <= i_cfg_data[CFGL_W-1:0];
                REG_SYS_LEN: r_sys_len <= i_cfg_data[CFGL_W-1:0];
                default: ;
            endcase
        end
    end

    // a new packet needs a free bank; bytes inside a packet always go in
    assign o_s_tready = r_receiving || !i_qstat.full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign is_sync    = (i_s_tdata == r_sync);

    // packet length from the type byte, held to the buffer range
    always_comb begin
        len_pick = (i_s_tdata == r_vel_id) ? LEN_W'(r_vel_len) : LEN_W'(r_sys_len);
        if (len_pick < LEN_W'(MIN_LENGTH)) begin
            len_clamp = LEN_W'(MIN_LENGTH);
        end else if (len_pick > LEN_W'(PACKET_DEPTH)) begin
            len_clamp = LEN_W'(PACKET_DEPTH);
        end else begin
            len_clamp = len_pick;
        end
    end

    assign done = r_receiving && (r_pos != POS_ONE)
                  && ((LEN_W'(r_pos) + LEN_W'(1)) >= r_len);

    // deframing state
    always_comb begin
        n_receiving = r_receiving;
        n_pos       = r_pos;
        n_len       = r_len;
        n_type      = r_type;
        n_bank      = r_bank;
        if (accept) begin
            if (!r_receiving) begin
                if (is_sync) begin
                    n_receiving = 1'b1;
                    n_pos       = POS_ONE;
                end
            end else if (r_pos == POS_ONE) begin
                n_len  = len_clamp;
                n_type = i_s_tdata;
                n_pos  = r_pos + 1'b1;
            end else if (done) begin
                n_receiving = 1'b0;
                n_pos       = '0;
                n_bank      = r_bank + 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_pos       <= '0;
            r_len       <= '0;
            r_bank      <= '0;
        end else begin
            r_receiving <= n_receiving;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_bank      <= n_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type <= n_type;
    end

    // byte write into the current bank
    assign o_wr.we   = accept && (r_receiving || is_sync);
    assign o_wr.addr = {r_bank, (r_receiving ? r_pos : t_pos'(0))};
    assign o_wr.data = i_s_tdata;

    // finished packet goes to the queue; kind uses the id current now
    assign o_push.valid    = accept && done;
    assign o_push.job.bank = r_bank;
    assign o_push.job.kind = (r_type == r_vel_id) ? KIND_VEL : KIND_SYS;

endmodule

// File: rtl/spdd_back.sv
// ----------------------------------------------------------------------------
// spdd_back
// Back end: walks the field table of the packet at the head of the queue,
// reads its bytes from the buffer and presents one decoded field at a time.
// ----------------------------------------------------------------------------
module spdd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // queue and buffer
    input  spdd_pkg::t_job    i_head,
    input  spdd_pkg::t_qstat  i_qstat,
    output logic              o_pop,
    output spdd_pkg::t_addr   o_raddr,
    input  spdd_pkg::t_byte   i_rdata,
    // field stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [31:0]       o_m_tdata,   // [3:0] field_index, [28:4] field_value
    output logic              o_m_tuser,   // [0] packet_kind
    output logic              o_m_tlast
);
    import spdd_pkg::*;

    t_bk_state r_state;
    t_bk_state n_state;
    t_fidx     r_idx;
    t_byte     r_b0;
    t_byte     r_b1;
    t_value    r_value;
    logic      r_last;
    t_desc     desc;
    t_pos      rpos;
    t_fidx     last_idx;
    logic      out_xfer;

    assign desc     = field_desc(i_head.kind, r_idx);
    assign last_idx = (i_head.kind == KIND_VEL) ? LAST_VEL : LAST_SYS;
    assign out_xfer = o_m_tvalid && i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (!i_qstat.empty) n_state = BK_RD0;
            BK_RD0:  n_state = BK_RD1;
            BK_RD1:  n_state = BK_RD2;
            BK_RD2:  n_state = BK_CAP;
            BK_CAP:  n_state = BK_OUT;
            BK_OUT: begin
                if (i_m_tready) begin
                    n_state = r_last ? BK_IDLE : BK_RD0;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        rpos       = desc.a0;
        o_m_tvalid = 1'b0;
        o_pop      = 1'b0;
        case (r_state)
            BK_RD0: rpos = desc.a0;
            BK_RD1: rpos = desc.a1;
            BK_RD2: rpos = desc.a2;
            BK_OUT: begin
                o_m_tvalid = 1'b1;
                o_pop      = i_m_tready && r_last;
            end
            default: rpos = desc.a0;
        endcase
    end

    assign o_raddr = {i_head.bank, rpos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_IDLE) begin
                r_idx <= '0;
            end else if (out_xfer && !r_last) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // gather bytes and build the field
    always_ff @(posedge i_clk) begin
        if (r_state == BK_RD1) begin
            r_b0 <= i_rdata;
        end
        if (r_state == BK_RD2) begin
            r_b1 <= i_rdata;
        end
        if (r_state == BK_CAP) begin
            r_value <= decode_value(desc.op, r_b0, r_b1, i_rdata);
            r_last  <= (r_idx == last_idx);
        end
    end

    assign o_m_tdata = {{(32 - VALUE_W - FIDX_W){1'b0}}, r_value, r_idx};
    assign o_m_tuser = i_head.kind;
    assign o_m_tlast = r_last;

`ifndef ASSERT_OFF
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |->
            (o_m_tuser == KIND_VEL && r_idx == LAST_VEL)
            || (o_m_tuser == KIND_SYS && r_idx == LAST_SYS))
        else $error("last field flag on wrong index");

    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !i_qstat.empty)
        else $error("field presented without a queued packet");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_m_tlast |=> !o_m_tvalid)
        else $error("field presented straight after packet end");
`endif

endmodule

// File: rtl/sensor_packet_deframe_decode_top.sv
// ----------------------------------------------------------------------------
// sensor_packet_deframe_decode_top
// Sync-byte packet deframer with field decode for velocity and system packets.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle. Each packet is written into one of
// two buffer banks; when its last byte arrives it is queued and the decoder
// emits its fields, 14 for a velocity packet and 12 for a system packet, one
// at a time (three buffer reads through the single read port, a decode step,
// an output step), passes through idle after each packet and waits on any
// output stall. The byte input stalls only when a new packet would start
// while both banks still hold packets waiting to be decoded. Register writes
// are taken at any time and should only be made while the block is idle.
module sensor_packet_deframe_decode_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // received bytes
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] rx_byte
    // decoded fields
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // [3:0] field_index, [28:4] field_value
    output logic        o_m_tuser,    // [0] packet_kind
    output logic        o_m_tlast,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import spdd_pkg::*;

    t_wr    wr;
    t_push  push;
    t_job   head;
    t_qstat qstat;
    logic   pop;
    t_addr  raddr;
    t_byte  rdata;

    // deframing front end
    spdd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (t_reg_idx'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .o_wr        (wr),
        .i_qstat     (qstat),
        .o_push      (push)
    );

    // packet buffer, two banks
    spdd_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (BYTE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // finished packet queue
    spdd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    // field decode back end
    spdd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_qstat    (qstat),
        .o_pop      (pop),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
